FILE: rtl/block_chain_validator_assert.svh
// Assertion macros for the block chain validator.
`ifndef BLOCK_CHAIN_VALIDATOR_ASSERT_SVH
`define BLOCK_CHAIN_VALIDATOR_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define BCV_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bcv assertion failed");

// Next-cycle implication, disabled while in reset.
`define BCV_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bcv assertion failed");

`endif

FILE: rtl/bcv_pkg.sv
// Types, constants and status codes shared by the block chain validator.
package bcv_pkg;

    localparam int UNPACKED_BLOCK_BYTES = 4096;
    localparam int WANT_W = $clog2(UNPACKED_BLOCK_BYTES + 1);
    localparam logic [31:0] HDR_BYTES  = 32'd6;
    localparam logic [31:0] MAX_PACKED = 32'h0001_0000;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_AREA_START = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FILE_SIZE       = CFG_IDX_W'(1);

    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_BLOCK = 1'b1;

    localparam logic [15:0] METHOD_STORED  = 16'd0;
    localparam logic [15:0] METHOD_IMPLODE = 16'd1;

    localparam logic [3:0] ST_MORE    = 4'd0;
    localparam logic [3:0] ST_DONE    = 4'd1;
    localparam logic [3:0] ST_BOUNDS  = 4'd2;
    localparam logic [3:0] ST_OVERRUN = 4'd3;
    localparam logic [3:0] ST_METHOD  = 4'd4;
    localparam logic [3:0] ST_RANGE   = 4'd5;
    localparam logic [3:0] ST_STORED  = 4'd6;
    localparam logic [3:0] ST_IMPLODE = 4'd7;
    localparam logic [3:0] ST_IDLE    = 4'd8;

    typedef struct packed {
        logic        func;
        logic [31:0] member_offset;
        logic [31:0] region_end;
        logic [31:0] unpacked_size;
        logic [15:0] block_method;
        logic [31:0] block_length;
    } t_item;

    typedef struct packed {
        logic [3:0]  status;
        logic [31:0] stream_size;
    } t_result;

    // current offset never passes region end, so 32 bits hold it
    typedef struct packed {
        logic        active;
        logic [31:0] start;
        logic [31:0] cur_off;
        logic [31:0] produced;
        logic [31:0] wanted_total;
        logic [31:0] region_end;
    } t_chain;

    typedef struct packed {
        logic [31:0] data_area_start;
        logic [31:0] file_size;
    } t_cfg;

endpackage

FILE: rtl/bcv_if.sv
// Valid/ready channel interfaces of the block chain validator.
interface bcv_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [31:0] member_offset;
    logic [31:0] region_end;
    logic [31:0] unpacked_size;
    logic [15:0] block_method;
    logic [31:0] block_length;

    modport source (output valid, func, member_offset, region_end, unpacked_size,
                    block_method, block_length, input ready);
    modport sink (input valid, func, member_offset, region_end, unpacked_size,
                  block_method, block_length, output ready);
endinterface

interface bcv_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  status;
    logic [31:0] stream_size;

    modport source (output valid, status, stream_size, input ready);
    modport sink (input valid, status, stream_size, output ready);
endinterface

interface bcv_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [bcv_pkg::CFG_IDX_W-1:0] index;
    logic [31:0]                  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/block_chain_validator.sv
// Top level of the block chain validator: input register, chain state, result register.
// An accepted word moves to the result register when the result slot is free or draining.
// One word per cycle unless stalled; chain state updates in the same cycle it is read.
// A stalled result holds the word in the input register; intake stops once both are full.
// Reset (synchronous, active low) empties both registers, closes any chain, zeroes config.
module block_chain_validator (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bcv_in_if.sink    i_in,
    bcv_out_if.source o_out,
    bcv_cfg_if.sink   i_cfg
);

    `include "block_chain_validator_assert.svh"

    // config registers
    bcv_pkg::t_cfg    w_cfg;

    // input register
    logic             r_in_valid;
    logic             n_in_valid;
    bcv_pkg::t_item   r_in;

    // chain state and its next value
    bcv_pkg::t_chain  r_chain;
    bcv_pkg::t_chain  n_chain;

    // result register
    logic             r_out_valid;
    logic             n_out_valid;
    bcv_pkg::t_result r_out;
    bcv_pkg::t_result n_out;

    logic             w_in_fire;
    logic             w_advance;
    logic             w_proc;

    bcv_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    bcv_check u_check (
        .i_item   (r_in),
        .i_chain  (r_chain),
        .i_cfg    (w_cfg),
        .o_chain  (n_chain),
        .o_result (n_out)
    );

    // the held word moves on when the result slot is free or being drained
    assign w_advance   = !r_out_valid || o_out.ready;
    assign w_proc      = r_in_valid && w_advance;
    assign i_in.ready  = !r_in_valid || w_advance;
    assign w_in_fire   = i_in.valid && i_in.ready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_in_fire) begin
            n_in_valid = 1'b1;
        end else if (w_proc) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (w_proc) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_chain     <= '0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (w_proc) begin
                r_chain <= n_chain;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_in.func          <= i_in.func;
            r_in.member_offset <= i_in.member_offset;
            r_in.region_end    <= i_in.region_end;
            r_in.unpacked_size <= i_in.unpacked_size;
            r_in.block_method  <= i_in.block_method;
            r_in.block_length  <= i_in.block_length;
        end
        if (w_proc) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_out.status;
    assign o_out.stream_size = r_out.stream_size;

    // an open chain never runs past its region end
    `BCV_ASSERT_NOW(a_off_in_region, i_clk, i_rst_n, r_chain.active,
                    r_chain.cur_off <= r_chain.region_end)

    // only a completion carries a stream length
    `BCV_ASSERT_NOW(a_size_only_done, i_clk, i_rst_n,
                    r_out_valid && r_out.status != bcv_pkg::ST_DONE,
                    r_out.stream_size == 32'd0)

    // a block word with no open chain reports no active chain
    `BCV_ASSERT_NEXT(a_idle_block, i_clk, i_rst_n,
                     w_proc && r_in.func == bcv_pkg::FUNC_BLOCK && !r_chain.active,
                     r_out_valid && r_out.status == bcv_pkg::ST_IDLE)

    // any result other than need-more leaves the chain closed
    `BCV_ASSERT_NEXT(a_close_on_end, i_clk, i_rst_n,
                     w_proc && n_out.status != bcv_pkg::ST_MORE, !r_chain.active)

endmodule

FILE: rtl/bcv_cfg.sv
// Configuration register file: data-area start and file size.
module bcv_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bcv_cfg_if.sink       i_cfg,
    output bcv_pkg::t_cfg o_cfg
);

    bcv_pkg::t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            // writes past the register list are dropped
            if (i_cfg.index == bcv_pkg::CFG_DATA_AREA_START) begin
                r_cfg.data_area_start <= i_cfg.data;
            end else if (i_cfg.index == bcv_pkg::CFG_FILE_SIZE) begin
                r_cfg.file_size <= i_cfg.data;
            end
        end
    end

endmodule

FILE: rtl/bcv_check.sv
// Per-word chain check: next chain state and result from one word.
module bcv_check (
    input  bcv_pkg::t_item   i_item,
    input  bcv_pkg::t_chain  i_chain,
    input  bcv_pkg::t_cfg    i_cfg,
    output bcv_pkg::t_chain  o_chain,
    output bcv_pkg::t_result o_result
);

    logic [32:0]                  w_body;
    logic [31:0]                  w_room;
    logic [31:0]                  w_remaining;
    logic [bcv_pkg::WANT_W-1:0]   w_wanted;
    logic [31:0]                  w_produced;
    logic [31:0]                  w_new_off;
    logic                         w_bad_bounds;

    always_comb begin
        w_body      = {1'b0, i_chain.cur_off} + {1'b0, bcv_pkg::HDR_BYTES};
        w_room      = i_chain.region_end - w_body[31:0];
        w_remaining = i_chain.wanted_total - i_chain.produced;
        if (w_remaining < 32'(bcv_pkg::UNPACKED_BLOCK_BYTES)) begin
            w_wanted = w_remaining[bcv_pkg::WANT_W-1:0];
        end else begin
            w_wanted = bcv_pkg::WANT_W'(bcv_pkg::UNPACKED_BLOCK_BYTES);
        end
        w_produced   = i_chain.produced + 32'(w_wanted);
        w_new_off    = w_body[31:0] + i_item.block_length;
        w_bad_bounds = (i_item.member_offset < i_cfg.data_area_start)
                    || (i_item.region_end > i_cfg.file_size)
                    || (i_item.member_offset > i_item.region_end);

        o_chain  = i_chain;
        o_result = '{status: bcv_pkg::ST_MORE, stream_size: 32'd0};

        if (i_item.func == bcv_pkg::FUNC_START) begin
            o_chain.active = 1'b0;
            if (w_bad_bounds) begin
                o_result.status = bcv_pkg::ST_BOUNDS;
            end else begin
                o_chain.start        = i_item.member_offset;
                o_chain.cur_off      = i_item.member_offset;
                o_chain.region_end   = i_item.region_end;
                o_chain.produced     = 32'd0;
                o_chain.wanted_total = i_item.unpacked_size;
                if (i_item.unpacked_size == 32'd0) begin
                    o_result.status = bcv_pkg::ST_DONE;
                end else begin
                    o_chain.active = 1'b1;
                end
            end
        end else begin
            priority if (!i_chain.active) begin
                o_result.status = bcv_pkg::ST_IDLE;
            end else if (w_body > {1'b0, i_chain.region_end}) begin
                o_chain.active  = 1'b0;
                o_result.status = bcv_pkg::ST_OVERRUN;
            end else if (i_item.block_method != bcv_pkg::METHOD_STORED
                      && i_item.block_method != bcv_pkg::METHOD_IMPLODE) begin
                o_chain.active  = 1'b0;
                o_result.status = bcv_pkg::ST_METHOD;
            end else if (i_item.block_length > bcv_pkg::MAX_PACKED
                      || i_item.block_length > w_room) begin
                o_chain.active  = 1'b0;
                o_result.status = bcv_pkg::ST_RANGE;
            end else if (i_item.block_method == bcv_pkg::METHOD_STORED
                      && i_item.block_length != 32'(w_wanted)) begin
                o_chain.active  = 1'b0;
                o_result.status = bcv_pkg::ST_STORED;
            end else if (i_item.block_method == bcv_pkg::METHOD_IMPLODE
                      && i_item.block_length == 32'd0) begin
                o_chain.active  = 1'b0;
                o_result.status = bcv_pkg::ST_IMPLODE;
            end else begin
                o_chain.produced = w_produced;
                o_chain.cur_off  = w_new_off;
                if (w_produced >= i_chain.wanted_total) begin
                    o_chain.active       = 1'b0;
                    o_result.status      = bcv_pkg::ST_DONE;
                    o_result.stream_size = w_new_off - i_chain.start;
                end
            end
        end
    end

endmodule

FILE: bench/block_chain_validator_tb.sv
// Self-checking testbench for the block chain validator: directed plan, random chains, stalls.
module block_chain_validator_tb;
    import bcv_pkg::*;

    localparam int          HALF_PERIOD  = 5;
    localparam int          TIMEOUT      = 5_000_000;
    localparam int          LONG_HOLD    = 250;
    localparam int          SETTLE_EDGES = 8;
    localparam int          CHAIN_CAP    = 14;
    // index values the block has no register for; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = CFG_IDX_W'(3);

    typedef struct {
        t_item   w;
        bit      typed;
        t_result res;
    } t_row;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    bcv_in_if  in_ch ();
    bcv_out_if out_ch ();
    bcv_cfg_if cfg_ch ();

    block_chain_validator dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always #HALF_PERIOD clk = ~clk;

    // register shadow and chain state of the predictor
    logic [31:0] cfg_area_start = '0;
    logic [31:0] cfg_file_size  = '0;
    logic        chain_open     = 1'b0;
    logic [31:0] chain_base     = '0;
    logic [32:0] run_off        = '0;
    logic [31:0] got_bytes      = '0;
    logic [31:0] want_bytes     = '0;
    logic [31:0] lim_end        = '0;

    t_result     owed_results[$];
    int          mismatches       = 0;
    int          words_sent       = 0;
    int          results_seen     = 0;
    int          chains_completed = 0;
    int          settings_used    = 1;
    bit [8:0]    seen_status      = '0;
    bit          long_hold_req    = 1'b0;
    int          src_calm_left    = 0;

    // Status and stream length for one word; updates the chain state.
    function automatic t_result validate_word(input t_item w);
        t_result     r;
        logic [63:0] body;
        logic [63:0] rend64;
        logic [31:0] remaining;
        logic [31:0] need;
        r.status      = ST_MORE;
        r.stream_size = '0;
        if (w.func == FUNC_START) begin
            chain_open = 1'b0;
            if (w.member_offset < cfg_area_start || w.region_end > cfg_file_size ||
                    w.member_offset > w.region_end) begin
                r.status = ST_BOUNDS;
                return r;
            end
            chain_base = w.member_offset;
            run_off    = {1'b0, w.member_offset};
            lim_end    = w.region_end;
            got_bytes  = '0;
            want_bytes = w.unpacked_size;
            if (w.unpacked_size == 0)
                r.status = ST_DONE;
            else
                chain_open = 1'b1;
            return r;
        end
        if (!chain_open) begin
            r.status = ST_IDLE;
            return r;
        end
        rend64 = {32'd0, lim_end};
        body   = {31'd0, run_off} + {32'd0, HDR_BYTES};
        if (body > rend64) begin
            r.status = ST_OVERRUN;
        end else if (w.block_method != METHOD_STORED && w.block_method != METHOD_IMPLODE) begin
            r.status = ST_METHOD;
        end else if (w.block_length > MAX_PACKED || {32'd0, w.block_length} > rend64 - body) begin
            r.status = ST_RANGE;
        end else begin
            remaining = want_bytes - got_bytes;
            need = (remaining < 32'(UNPACKED_BLOCK_BYTES)) ? remaining
                                                           : 32'(UNPACKED_BLOCK_BYTES);
            if (w.block_method == METHOD_STORED && w.block_length != need) begin
                r.status = ST_STORED;
            end else if (w.block_method == METHOD_IMPLODE && w.block_length == 0) begin
                r.status = ST_IMPLODE;
            end else begin
                got_bytes = got_bytes + need;
                run_off   = body[32:0] + {1'b0, w.block_length};
                if (got_bytes >= want_bytes) begin
                    chain_open    = 1'b0;
                    r.status      = ST_DONE;
                    r.stream_size = 32'(run_off - {1'b0, chain_base});
                end
                return r;
            end
        end
        chain_open = 1'b0;
        return r;
    endfunction

    // mostly the shortest gaps, a few long ones
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 1;
        if (r < 92)
            return $urandom_range(2, 4);
        return $urandom_range(10, 40);
    endfunction

    function automatic t_row mk_row(input logic fn, input logic [31:0] off,
                                    input logic [31:0] rend, input logic [31:0] usize,
                                    input logic [15:0] meth, input logic [31:0] len,
                                    input bit typed, input logic [3:0] st,
                                    input logic [31:0] sz);
        t_row row;
        row.w.func          = fn;
        row.w.member_offset = off;
        row.w.region_end    = rend;
        row.w.unpacked_size = usize;
        row.w.block_method  = meth;
        row.w.block_length  = len;
        row.typed           = typed;
        row.res.status      = st;
        row.res.stream_size = sz;
        return row;
    endfunction

    // Chain opener, mostly inside the configured area; some deliberately out of bounds.
    function automatic t_item make_start();
        t_item       w;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] off;
        logic [63:0] span;
        int          r;
        w.func         = FUNC_START;
        w.block_method = 16'($urandom);
        w.block_length = $urandom;
        lo = {32'd0, cfg_area_start};
        hi = {32'd0, cfg_file_size};
        if (lo > hi || $urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 2))
                0: begin
                    w.member_offset = cfg_area_start - 1;
                    w.region_end    = cfg_file_size;
                end
                1: begin
                    w.member_offset = cfg_area_start;
                    w.region_end    = cfg_file_size + 1;
                end
                default: begin
                    w.member_offset = cfg_area_start + 1;
                    w.region_end    = cfg_area_start;
                end
            endcase
        end else begin
            off  = lo + $urandom_range(0, ((hi - lo) < 64'h800) ? 32'(hi - lo) : 32'h800);
            r    = $urandom_range(0, 99);
            if (r < 15)
                span = $urandom_range(0, 64);
            else if (r < 20)
                span = hi - off;
            else
                span = $urandom_range(32'h100, 32'h3_0000);
            if (span > hi - off)
                span = hi - off;
            w.member_offset = 32'(off);
            w.region_end    = 32'(off + span);
        end
        r = $urandom_range(0, 99);
        if (r < 10)
            w.unpacked_size = '0;
        else if (r < 70)
            w.unpacked_size = $urandom_range(1, 20000);
        else if (r < 90)
            w.unpacked_size = $urandom_range(1, UNPACKED_BLOCK_BYTES);
        else
            w.unpacked_size = $urandom;
        return w;
    endfunction

    // Block header for the open chain: mostly well formed, now and then broken.
    function automatic t_item make_block();
        t_item       w;
        logic [31:0] remaining;
        logic [31:0] need;
        int          r;
        w.func          = FUNC_BLOCK;
        w.member_offset = $urandom;
        w.region_end    = $urandom;
        w.unpacked_size = $urandom;
        remaining = want_bytes - got_bytes;
        need = (remaining < 32'(UNPACKED_BLOCK_BYTES)) ? remaining : 32'(UNPACKED_BLOCK_BYTES);
        r = $urandom_range(0, 99);
        if (r < 55) begin
            w.block_method = METHOD_STORED;
            w.block_length = need;
        end else if (r < 88) begin
            w.block_method = METHOD_IMPLODE;
            case ($urandom_range(0, 9))
                7, 8:    w.block_length = $urandom_range(1, MAX_PACKED);
                9:       w.block_length = MAX_PACKED;
                default: w.block_length = $urandom_range(1, need + 256);
            endcase
        end else if (r < 92) begin
            w.block_method = 16'($urandom_range(2, 65535));
            w.block_length = need;
        end else if (r < 96) begin
            w.block_method = METHOD_STORED;
            w.block_length = $urandom_range(0, 1) ? need - 1 : need + $urandom_range(1, 3);
        end else begin
            w.block_method = METHOD_IMPLODE;
            case ($urandom_range(0, 2))
                0:       w.block_length = '0;
                1:       w.block_length = MAX_PACKED + $urandom_range(1, 32'hFFFF);
                default: w.block_length = $urandom;
            endcase
        end
        return w;
    endfunction

    // Offers one word after a random gap, then predicts once it is taken.
    task automatic offer_word(input t_item w, input bit typed, input t_result typed_res);
        int      gap;
        t_result pred;
        if (src_calm_left > 0) begin
            src_calm_left--;
            gap = 0;
        end else if ($urandom_range(0, 99) < 3) begin
            src_calm_left = $urandom_range(20, 60);
            gap = 0;
        end else if ($urandom_range(0, 99) < 55) begin
            gap = 0;
        end else begin
            gap = pick_idle();
        end
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.func          <= w.func;
        in_ch.member_offset <= w.member_offset;
        in_ch.region_end    <= w.region_end;
        in_ch.unpacked_size <= w.unpacked_size;
        in_ch.block_method  <= w.block_method;
        in_ch.block_length  <= w.block_length;
        do @(posedge clk); while (!in_ch.ready);
        pred = validate_word(w);
        owed_results.push_back(typed ? typed_res : pred);
        words_sent++;
    endtask

    // Sender goes quiet until every owed result is back, then lets the pipe settle.
    task automatic await_drain();
        in_ch.valid <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_EDGES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == CFG_DATA_AREA_START)
            cfg_area_start = val;
        else if (idx == CFG_FILE_SIZE)
            cfg_file_size = val;
        @(posedge clk);
    endtask

    // One register setting: chains with random content, some noise, a long sink
    // hold-off a third of the way in and a full drain two thirds in.
    task automatic run_phase(input logic [31:0] das, input logic [31:0] fs,
                             input int n_words);
        int    done_words;
        int    blocks;
        bit    held;
        bit    paused;
        t_item w;
        t_result none;
        none       = '0;
        done_words = 0;
        held       = 1'b0;
        paused     = 1'b0;
        await_drain();
        write_reg(CFG_DATA_AREA_START, das);
        write_reg(CFG_FILE_SIZE, fs);
        settings_used++;
        while (done_words < n_words) begin
            if (!held && done_words >= n_words / 3) begin
                long_hold_req = 1'b1;
                held = 1'b1;
            end
            if (!paused && done_words >= 2 * n_words / 3) begin
                await_drain();
                paused = 1'b1;
            end
            if ($urandom_range(0, 99) < 10) begin
                w.func          = 1'($urandom_range(0, 1));
                w.member_offset = $urandom;
                w.region_end    = $urandom;
                w.unpacked_size = $urandom;
                w.block_method  = 16'($urandom);
                w.block_length  = $urandom;
                offer_word(w, 1'b0, none);
                done_words++;
            end else begin
                offer_word(make_start(), 1'b0, none);
                done_words++;
                blocks = 0;
                while (chain_open && blocks < CHAIN_CAP && done_words < n_words) begin
                    offer_word(make_block(), 1'b0, none);
                    done_words++;
                    blocks++;
                end
                // straggler header after the chain closed
                if (!chain_open && $urandom_range(0, 19) == 0) begin
                    offer_word(make_block(), 1'b0, none);
                    done_words++;
                end
            end
        end
    endtask

    // Result side: random backpressure, calm stretches, and a long hold on request.
    initial begin : sink_side
        int      stall_left;
        int      calm_left;
        int      r;
        t_result due;
        stall_left = 0;
        calm_left  = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready) begin
                if (owed_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: result word with nothing owed: status=%0d size=%08h",
                             $time, out_ch.status, out_ch.stream_size);
                end else begin
                    due = owed_results.pop_front();
                    results_seen++;
                    if (out_ch.status !== due.status) begin
                        mismatches++;
                        $display("%0t: status mismatch: expected %0d, got %0d",
                                 $time, due.status, out_ch.status);
                    end
                    if (out_ch.stream_size !== due.stream_size) begin
                        mismatches++;
                        $display("%0t: stream_size mismatch: expected %08h, got %08h",
                                 $time, due.stream_size, out_ch.stream_size);
                    end
                    if (due.status <= ST_IDLE)
                        seen_status[due.status] = 1'b1;
                    if (due.status == ST_DONE)
                        chains_completed++;
                end
            end
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left    = LONG_HOLD;
                calm_left     = 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (calm_left > 0) begin
                calm_left--;
                out_ch.ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 4) begin
                    calm_left = $urandom_range(30, 120);
                    out_ch.ready <= 1'b1;
                end else if (r < 22) begin
                    stall_left = pick_idle() - 1;
                    out_ch.ready <= 1'b0;
                end else begin
                    out_ch.ready <= 1'b1;
                end
            end
        end
    end

    initial begin : stimulus
        t_row plan[27];
        in_ch.valid         <= 1'b0;
        in_ch.func          <= FUNC_START;
        in_ch.member_offset <= '0;
        in_ch.region_end    <= '0;
        in_ch.unpacked_size <= '0;
        in_ch.block_method  <= METHOD_STORED;
        in_ch.block_length  <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= CFG_DATA_AREA_START;
        cfg_ch.data         <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // first three rows run on the all-zero registers left by reset
        plan[0]  = mk_row(FUNC_BLOCK, 0, 0, 0, METHOD_STORED, 0, 1, ST_IDLE, 0);
        plan[1]  = mk_row(FUNC_START, 0, 0, 0, METHOD_STORED, 0, 1, ST_DONE, 0);
        plan[2]  = mk_row(FUNC_START, 0, 1, 5, METHOD_STORED, 0, 1, ST_BOUNDS, 0);
        // area 0x1000 .. 0x100000 from here on
        plan[3]  = mk_row(FUNC_START, 32'h0FFF, 32'h2000, 100, METHOD_STORED, 0,
                          1, ST_BOUNDS, 0);
        plan[4]  = mk_row(FUNC_START, 32'h2000, 32'h1FFF, 100, METHOD_STORED, 0,
                          1, ST_BOUNDS, 0);
        plan[5]  = mk_row(FUNC_START, 32'h1000, 32'h0010_0001, 100, METHOD_STORED, 0,
                          1, ST_BOUNDS, 0);
        // block fields on a start are don't-care
        plan[6]  = mk_row(FUNC_START, 32'h1000, 32'h0010_0000, 10000, 16'hFFFF,
                          32'hFFFF_FFFF, 1, ST_MORE, 0);
        plan[7]  = mk_row(FUNC_BLOCK, 0, 0, 0, METHOD_STORED, 4096, 0, ST_MORE, 0);
        plan[8]  = mk_row(FUNC_BLOCK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          METHOD_IMPLODE, 1, 0, ST_MORE, 0);
        plan[9]  = mk_row(FUNC_BLOCK, 0, 0, 0, METHOD_STORED, 1808, 0, ST_MORE, 0);
        plan[10] = mk_row(FUNC_BLOCK, 0, 0, 0, METHOD_STORED, 0, 1, ST_IDLE, 0);
        // region too short for even one header
        plan[11] = mk_row(FUNC_START, 32'h1000, 32'h1005, 1, METHOD_STORED, 0, 0, ST_MORE, 0);
        plan[12] = mk_row(FUNC_BLOCK, 0, 0, 0, METHOD_IMPLODE, 1, 1, ST_OVERRUN, 0);
        plan[13] = mk_row(FUNC_START, 32'h1000, 32'h0010_0000, 5000, METHOD_STORED, 0,
                          0, ST_MORE, 0);
        plan[14] = mk_row(FUNC_BLOCK, 0, 0, 0, 16'hFFFF, 1, 1, ST_METHOD, 0);
        plan[15] = plan[13];
        plan[16] = mk_row(FUNC_BLOCK, 0, 0, 0, METHOD_IMPLODE, MAX_PACKED + 1,
                          1, ST_RANGE, 0);
        // body of 10 bytes left before region end
        plan[17] = mk_row(FUNC_START, 32'h1000, 32'h1010, 5000, METHOD_STORED, 0, 0, ST_MORE, 0);
        plan[18] = mk_row(FUNC_BLOCK, 0, 0, 0, METHOD_IMPLODE, 11, 1, ST_RANGE, 0);
        plan[19] = plan[13];
        plan[20] = mk_row(FUNC_BLOCK, 0, 0, 0, METHOD_STORED, 4095, 1, ST_STORED, 0);
        plan[21] = plan[13];
        plan[22] = mk_row(FUNC_BLOCK, 0, 0, 0, METHOD_IMPLODE, 0, 1, ST_IMPLODE, 0);
        plan[23] = mk_row(FUNC_START, 32'h1000, 32'h0010_0000, 32'hFFFF_FFFF, METHOD_STORED, 0,
                          0, ST_MORE, 0);
        plan[24] = mk_row(FUNC_BLOCK, 0, 0, 0, METHOD_IMPLODE, MAX_PACKED, 0, ST_MORE, 0);
        // restart over an open chain with bad bounds leaves nothing open
        plan[25] = mk_row(FUNC_START, 32'hFFFF_FFFF, 32'h0010_0000, 1, METHOD_STORED, 0,
                          1, ST_BOUNDS, 0);
        plan[26] = mk_row(FUNC_BLOCK, 0, 0, 0, METHOD_STORED, 0, 1, ST_IDLE, 0);

        foreach (plan[i]) begin
            if (i == 3) begin
                await_drain();
                write_reg(CFG_DATA_AREA_START, 32'h0000_1000);
                write_reg(CFG_FILE_SIZE, 32'h0010_0000);
                write_reg(CFG_SPARE_2, 32'hFFFF_FFFF);
                write_reg(CFG_SPARE_3, 32'hA5A5_5A5A);
                settings_used++;
            end
            offer_word(plan[i].w, plan[i].typed, plan[i].res);
        end

        run_phase(32'h0000_1000, 32'h0010_0000, 170);
        run_phase(32'h0000_0000, 32'hFFFF_FFFF, 140);
        run_phase(32'hFFFF_0000, 32'hFFFF_FFFF, 130);
        run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 30);
        run_phase(32'h0000_0000, 32'h0000_0000, 20);
        run_phase($urandom_range(0, 32'hFFFF), $urandom, 130);
        await_drain();

        $display("run covered %0d words and %0d results over %0d register settings",
                 words_sent, results_seen, settings_used);
        $display("%0d chains completed, %0d of 9 status codes observed",
                 chains_completed, $countones(seen_status));
        if (mismatches == 0) begin
            $display("block_chain_validator verification clean");
        end else begin
            $display("block_chain_validator verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        #TIMEOUT;
        $display("%0t: timeout with %0d results still owed", $time, owed_results.size());
        $display("block_chain_validator verification failed");
        $finish;
    end

endmodule
